FILE: hw/rtl/checked_record_ring_macros.svh
// Assertion macros shared by the record ring RTL.
`ifndef CHECKED_RECORD_RING_MACROS_SVH
`define CHECKED_RECORD_RING_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CRR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checked_record_ring assertion failed");

// Next-cycle implication, disabled in reset.
`define CRR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checked_record_ring assertion failed");

`endif

FILE: hw/rtl/crr_pkg.sv
// Package with constants, types and the hash step of the record ring.
package crr_pkg;

    localparam int SLOT_COUNT    = 16;
    localparam int PAYLOAD_BYTES = 64;
    localparam int SLOT_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LEN_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int PAY_DEPTH     = SLOT_COUNT * PAYLOAD_BYTES;
    localparam int PAY_AW        = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;

    localparam logic OP_PUBLISH = 1'b0;
    localparam logic OP_POLL    = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_BAD_LEN  = 3'd4,
        ST_BAD_SUM  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        DROP_NONE = 2'd0,
        DROP_FULL = 2'd1,
        DROP_LONG = 2'd2
    } drop_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_META,
        S_HRD,
        S_HST,
        S_CMP,
        S_ERD,
        S_ELD,
        S_RES
    } state_t;

    typedef struct packed {
        logic [63:0]      seq;
        logic [63:0]      stamp;
        logic [LEN_W-1:0] len;
        logic [31:0]      hash;
    } meta_t;

    // only the low 32 bits of the product are kept
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] prod;
        prod = (h ^ {24'd0, b}) * HASH_PRIME;
        return prod;
    endfunction

endpackage

FILE: hw/rtl/crr_ram.sv
// Generic synchronous RAM: one write port, one registered read port.
module crr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/checked_record_ring.sv
// Publish: one word per cycle while in_stall is low; the last word's status is registered
// in the output register. Poll: a metadata check, a hash pass over the payload RAM (read,
// then hash, per byte), a compare, then a read and a load per delivered byte; an empty
// slot, a bad length or a bad checksum ends in a single status word. Only one poll runs at
// a time; the input stalls for its whole length. Reset (async, active low) clears indexes,
// fill state, valid bits and the output valid bit; RAM contents are undefined until written.
`include "checked_record_ring_macros.svh"
module checked_record_ring (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    operation,
    input  logic [63:0]             sequence_number,
    input  logic [63:0]             stamp_ns,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    output logic                    out_valid,
    input  logic                    out_stall,
    output crr_pkg::status_t        status,
    output logic [63:0]             out_sequence,
    output logic [63:0]             out_stamp_ns,
    output logic [7:0]              out_byte,
    output logic                    end_of_record
);
    import crr_pkg::*;

    state_t                  state_reg, state_next;
    logic [SLOT_W-1:0]       pidx_reg, cidx_reg;
    logic [LEN_W-1:0]        fill_reg;
    logic [31:0]             run_hash_reg;
    drop_t                   drop_reg, drop_eff;
    logic [SLOT_COUNT-1:0]   slot_valid_reg;
    logic [LEN_W-1:0]        idx_reg;
    logic [31:0]             chk_hash_reg;
    status_t                 res_code_reg;
    logic                    out_valid_reg;

    logic                    in_accept, pub_go, poll_go, out_free;
    logic [31:0]             hash_new;
    logic [LEN_W-1:0]        fill_inc, idx_inc;
    logic                    pay_we, meta_we;
    logic [PAY_AW-1:0]       pay_waddr, pay_raddr;
    logic [7:0]              pay_rd;
    meta_t                   meta_wd, meta_rd;
    logic                    len_bad, sum_bad, byte_last;
    logic                    res_load, byte_load;

    assign in_accept = in_valid && !in_stall;
    assign pub_go    = in_accept && (operation == OP_PUBLISH);
    assign poll_go   = in_accept && (operation == OP_POLL);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;

    // publish path
    always_comb
    begin
        drop_eff = drop_reg;
        if (fill_reg == '0 && drop_reg == DROP_NONE && slot_valid_reg[pidx_reg])
        begin
            drop_eff = DROP_FULL;
        end
        if (fill_reg >= LEN_W'(PAYLOAD_BYTES))
        begin
            drop_eff = DROP_LONG;
        end
    end

    assign hash_new  = fnv_step(run_hash_reg, data_byte);
    assign fill_inc  = LEN_W'(fill_reg + LEN_W'(1));
    assign pay_we    = pub_go && (drop_eff == DROP_NONE);
    assign meta_we   = pay_we && last_byte;
    assign pay_waddr = PAY_AW'(PAY_AW'(pidx_reg) * PAY_AW'(PAYLOAD_BYTES) + PAY_AW'(fill_reg));
    assign pay_raddr = PAY_AW'(PAY_AW'(cidx_reg) * PAY_AW'(PAYLOAD_BYTES) + PAY_AW'(idx_reg));
    assign meta_wd   = '{seq: sequence_number, stamp: stamp_ns, len: fill_inc, hash: hash_new};

    crr_ram #(.WIDTH(8), .DEPTH(PAY_DEPTH)) u_payload (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (data_byte),
        .raddr (pay_raddr),
        .rdata (pay_rd)
    );

    crr_ram #(.WIDTH($bits(meta_t)), .DEPTH(SLOT_COUNT)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (pidx_reg),
        .wdata (meta_wd),
        .raddr (cidx_reg),
        .rdata (meta_rd)
    );

    assign idx_inc   = LEN_W'(idx_reg + LEN_W'(1));
    assign len_bad   = (meta_rd.len == '0) || (meta_rd.len > LEN_W'(PAYLOAD_BYTES));
    assign sum_bad   = chk_hash_reg != meta_rd.hash;
    assign byte_last = idx_inc == meta_rd.len;

    // poll sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (poll_go)
                begin
                    state_next = slot_valid_reg[cidx_reg] ? S_META : S_RES;
                end
            end
            S_META: state_next = len_bad ? S_RES : S_HRD;
            S_HRD:  state_next = S_HST;
            S_HST:  state_next = byte_last ? S_CMP : S_HRD;
            S_CMP:  state_next = sum_bad ? S_RES : S_ERD;
            S_ERD:  state_next = S_ELD;
            S_ELD:
            begin
                if (out_free)
                begin
                    state_next = byte_last ? S_IDLE : S_ERD;
                end
            end
            S_RES:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // poll sequencer: outputs
    always_comb
    begin
        res_load  = 1'b0;
        byte_load = 1'b0;
        case (state_reg)
            S_RES:   res_load  = out_free;
            S_ELD:   byte_load = out_free;
            default:
            begin
                res_load  = 1'b0;
                byte_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pidx_reg       <= '0;
            cidx_reg       <= '0;
            fill_reg       <= '0;
            run_hash_reg   <= HASH_BASIS;
            drop_reg       <= DROP_NONE;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pub_go)
            begin
                if (last_byte)
                begin
                    if (drop_eff == DROP_NONE)
                    begin
                        slot_valid_reg[pidx_reg] <= 1'b1;
                        pidx_reg <= (pidx_reg == SLOT_W'(SLOT_COUNT - 1)) ?
                                    '0 : SLOT_W'(pidx_reg + SLOT_W'(1));
                    end
                    fill_reg     <= '0;
                    run_hash_reg <= HASH_BASIS;
                    drop_reg     <= DROP_NONE;
                end
                else
                begin
                    if (drop_eff == DROP_NONE)
                    begin
                        run_hash_reg <= hash_new;
                    end
                    if (fill_reg < LEN_W'(PAYLOAD_BYTES))
                    begin
                        fill_reg <= fill_inc;
                    end
                    drop_reg <= drop_eff;
                end
            end
            if (byte_load && byte_last)
            begin
                slot_valid_reg[cidx_reg] <= 1'b0;
                cidx_reg <= (cidx_reg == SLOT_W'(SLOT_COUNT - 1)) ?
                            '0 : SLOT_W'(cidx_reg + SLOT_W'(1));
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((pub_go && last_byte) || res_load || byte_load)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                res_code_reg <= ST_EMPTY;
                idx_reg      <= '0;
            end
            S_META:
            begin
                res_code_reg <= ST_BAD_LEN;
                idx_reg      <= '0;
                chk_hash_reg <= HASH_BASIS;
            end
            S_HST:
            begin
                chk_hash_reg <= fnv_step(chk_hash_reg, pay_rd);
                idx_reg      <= idx_inc;
            end
            S_CMP:
            begin
                res_code_reg <= ST_BAD_SUM;
                idx_reg      <= '0;
            end
            S_ELD:
            begin
                if (out_free)
                begin
                    idx_reg <= idx_inc;
                end
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase

        if (pub_go && last_byte)
        begin
            case (drop_eff)
                DROP_FULL: status <= ST_FULL;
                DROP_LONG: status <= ST_TOO_LONG;
                default:   status <= ST_OK;
            endcase
            out_sequence  <= '0;
            out_stamp_ns  <= '0;
            out_byte      <= '0;
            end_of_record <= 1'b1;
        end
        else if (res_load)
        begin
            status        <= res_code_reg;
            out_sequence  <= '0;
            out_stamp_ns  <= '0;
            out_byte      <= '0;
            end_of_record <= 1'b1;
        end
        else if (byte_load)
        begin
            status        <= ST_OK;
            out_sequence  <= meta_rd.seq;
            out_stamp_ns  <= meta_rd.stamp;
            out_byte      <= pay_rd;
            end_of_record <= byte_last;
        end
    end

    `CRR_ASSERT_NOW(a_busy_stalls, state_reg != S_IDLE, in_stall)
    `CRR_ASSERT_NEXT(a_consume_on_last, byte_load && byte_last, out_valid_reg && end_of_record)
    `CRR_ASSERT_NOW(a_consume_moves, cidx_reg != $past(cidx_reg), $past(state_reg) == S_ELD)
    `CRR_ASSERT_NEXT(a_poll_busy, poll_go, state_reg != S_IDLE)

endmodule

FILE: tb/crr_checker.sv
// Checker for the record ring: watches both channels, predicts results and compares them.
module crr_checker
    import crr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic             operation,
    input  logic [63:0]      sequence_number,
    input  logic [63:0]      stamp_ns,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic             out_valid,
    input  logic             out_stall,
    input  status_t          status,
    input  logic [63:0]      out_sequence,
    input  logic [63:0]      out_stamp_ns,
    input  logic [7:0]       out_byte,
    input  logic             end_of_record,
    output int               fail_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     st;
        logic [63:0] seq;
        logic [63:0] stamp;
        logic [7:0]  data;
        logic        eor;
    } word_t;

    word_t       expected_words[$];
    logic [7:0]  ring_bytes[SLOT_COUNT][PAYLOAD_BYTES];
    logic [63:0] ring_seq[SLOT_COUNT];
    logic [63:0] ring_stamp[SLOT_COUNT];
    int          ring_len[SLOT_COUNT];
    logic [31:0] ring_sum[SLOT_COUNT];
    logic        ring_full_bit[SLOT_COUNT];
    int          wr_slot, rd_slot, fill;
    logic [31:0] run_sum;
    drop_t       drop;

    function automatic logic [31:0] fnv(input logic [31:0] h, input logic [7:0] b);
        logic [63:0] p;
        p = 64'(h ^ {24'd0, b}) * 64'd16777619;
        return p[31:0];
    endfunction

    task automatic push_word(input status_t st, input logic [63:0] sq,
                             input logic [63:0] sp, input logic [7:0] d, input logic e);
        word_t w;
        w.st = st; w.seq = sq; w.stamp = sp; w.data = d; w.eor = e;
        expected_words.push_back(w);
    endtask

    task automatic predict_publish();
        if (fill == 0 && drop == DROP_NONE && ring_full_bit[wr_slot])
            drop = DROP_FULL;
        if (fill >= PAYLOAD_BYTES)
            drop = DROP_LONG;
        if (drop == DROP_NONE)
        begin
            ring_bytes[wr_slot][fill] = data_byte;
            run_sum = fnv(run_sum, data_byte);
        end
        if (fill < PAYLOAD_BYTES)
            fill++;
        if (last_byte)
        begin
            if (drop == DROP_NONE)
            begin
                ring_seq[wr_slot] = sequence_number;
                ring_stamp[wr_slot] = stamp_ns;
                ring_len[wr_slot] = fill;
                ring_sum[wr_slot] = run_sum;
                ring_full_bit[wr_slot] = 1'b1;
                wr_slot = (wr_slot + 1) % SLOT_COUNT;
                push_word(ST_OK, '0, '0, '0, 1'b1);
            end
            else
                push_word(drop == DROP_FULL ? ST_FULL : ST_TOO_LONG, '0, '0, '0, 1'b1);
            fill = 0;
            run_sum = HASH_BASIS;
            drop = DROP_NONE;
        end
    endtask

    task automatic predict_poll();
        logic [31:0] h;
        int n;
        if (!ring_full_bit[rd_slot])
        begin
            push_word(ST_EMPTY, '0, '0, '0, 1'b1);
            return;
        end
        n = ring_len[rd_slot];
        if (n == 0 || n > PAYLOAD_BYTES)
        begin
            push_word(ST_BAD_LEN, '0, '0, '0, 1'b1);
            return;
        end
        h = HASH_BASIS;
        for (int i = 0; i < n; i++)
            h = fnv(h, ring_bytes[rd_slot][i]);
        if (h != ring_sum[rd_slot])
        begin
            push_word(ST_BAD_SUM, '0, '0, '0, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++)
            push_word(ST_OK, ring_seq[rd_slot], ring_stamp[rd_slot],
                      ring_bytes[rd_slot][i], i + 1 == n);
        ring_full_bit[rd_slot] = 1'b0;
        rd_slot = (rd_slot + 1) % SLOT_COUNT;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        word_t w;
        if (!rst_n)
        begin
            expected_words.delete();
            for (int i = 0; i < SLOT_COUNT; i++)
                ring_full_bit[i] = 1'b0;
            wr_slot = 0; rd_slot = 0; fill = 0;
            run_sum = HASH_BASIS;
            drop = DROP_NONE;
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            // check the output first: a result never comes in the cycle its word is taken
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word, status %0d", status);
                    fail_count++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (status !== w.st)
                    begin
                        $error("status: expected %0d, actual %0d", w.st, status);
                        fail_count++;
                    end
                    if (out_sequence !== w.seq)
                    begin
                        $error("out_sequence: expected %h, actual %h", w.seq, out_sequence);
                        fail_count++;
                    end
                    if (out_stamp_ns !== w.stamp)
                    begin
                        $error("out_stamp_ns: expected %h, actual %h", w.stamp, out_stamp_ns);
                        fail_count++;
                    end
                    if (out_byte !== w.data)
                    begin
                        $error("out_byte: expected %h, actual %h", w.data, out_byte);
                        fail_count++;
                    end
                    if (end_of_record !== w.eor)
                    begin
                        $error("end_of_record: expected %b, actual %b", w.eor, end_of_record);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (operation == OP_PUBLISH)
                    predict_publish();
                else
                    predict_poll();
            end
            pending_count = expected_words.size();
        end
    end
endmodule

FILE: tb/tb_checked_record_ring.sv
// Top of the record ring testbench: clock, reset, stimulus, stall patterns and verdict.
module tb_checked_record_ring;
    timeunit 1ns;
    timeprecision 1ps;
    import crr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [63:0] sequence_number;
    logic [63:0] stamp_ns;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    status_t     status;
    logic [63:0] out_sequence;
    logic [63:0] out_stamp_ns;
    logic [7:0]  out_byte;
    logic        end_of_record;
    int          fail_count;
    int          pending_count;
    bit          calm;
    bit          hold_off;
    int          words_sent;

    checked_record_ring dut (.*);

    crr_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // send one word, with random idle cycles before it unless in a calm stretch
    task automatic send_word(input logic op, input logic [7:0] d, input logic lst);
        while (!calm && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        data_byte <= d;
        last_byte <= lst;
        sequence_number <= {$urandom, $urandom};
        stamp_ns <= {$urandom, $urandom};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_record(input int n);
        for (int i = 0; i < n; i++)
            send_word(OP_PUBLISH, 8'($urandom), i == n - 1);
    endtask

    task automatic random_len(output int n);
        int r;
        r = $urandom_range(99);
        if (r < 5)
            n = $urandom_range(66, 70);
        else if (r < 15)
            n = $urandom_range(60, 64);
        else
            n = $urandom_range(1, 6);
    endtask

    // receiver stall pattern
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            out_stall <= !calm && $urandom_range(99) < 9;
        end
    end

    initial
    begin
        #20ms;
        $display("tb_checked_record_ring: errors");
        $finish;
    end

    initial
    begin
        int n;
        int r;
        in_valid = 1'b0;
        operation = OP_PUBLISH;
        sequence_number = '0;
        stamp_ns = '0;
        data_byte = '0;
        last_byte = 1'b0;
        calm = 1'b0;
        hold_off = 1'b0;
        words_sent = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty poll, extremes of bytes, max length, too long, ring full
        send_word(OP_POLL, 8'hff, 1'b1);
        send_word(OP_PUBLISH, 8'h00, 1'b1);
        send_word(OP_PUBLISH, 8'hff, 1'b0);
        send_word(OP_PUBLISH, 8'h5a, 1'b1);
        send_word(OP_POLL, 8'h00, 1'b0);
        send_word(OP_POLL, 8'h00, 1'b0);
        send_word(OP_POLL, 8'h00, 1'b0);
        send_record(PAYLOAD_BYTES);
        send_word(OP_POLL, 8'h00, 1'b0);
        send_record(PAYLOAD_BYTES + 2);
        for (int i = 0; i < SLOT_COUNT + 1; i++)
            send_word(OP_PUBLISH, 8'($urandom), 1'b1);
        send_record(3);
        hold_off = 1'b1;
        for (int i = 0; i < SLOT_COUNT + 2; i++)
            send_word(OP_POLL, 8'h00, 1'b0);

        // random: mostly whole records with polls, one calm stretch
        while (words_sent < 280)
        begin
            calm = (words_sent > 190 && words_sent < 250);
            r = $urandom_range(99);
            if (r < 55)
            begin
                random_len(n);
                send_record(n);
            end
            else if (r < 90)
                send_word(OP_POLL, 8'($urandom), 1'($urandom));
            else
                send_word(OP_PUBLISH, 8'($urandom), 1'($urandom));
        end
        calm = 1'b0;
        send_word(OP_PUBLISH, 8'h11, 1'b1);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_checked_record_ring: clean");
        else
            $display("tb_checked_record_ring: errors");
        $finish;
    end
endmodule
